// File: hw/rtl/sfha_pkg.sv
`timescale 1ns / 1ps
package sfha_pkg;

  localparam int ADDR_BITS = 48;

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [1:0]           opcode_t;
  typedef logic [2:0]           status_t;
  typedef logic [1:0]           cfg_idx_t;

  localparam opcode_t OP_ALLOC   = 2'd0;
  localparam opcode_t OP_RELEASE = 2'd1;
  localparam opcode_t OP_QUERY   = 2'd2;

  localparam status_t ST_OK      = 3'd0;
  localparam status_t ST_NOFIT   = 3'd1;
  localparam status_t ST_REJ     = 3'd2;
  localparam status_t ST_UNKNOWN = 3'd3;
  localparam status_t ST_FULL    = 3'd4;

  localparam cfg_idx_t CFG_BASE   = 2'd0;
  localparam cfg_idx_t CFG_SIZE   = 2'd1;
  localparam cfg_idx_t CFG_THRESH = 2'd2;

  // last drain counter value after the last read of a scan; once reached, its pipeline is empty
  localparam logic [1:0] DRAIN_LAST = 2'd3;

  typedef struct packed {
    logic       fit;
    logic [5:0] bucket;
    addr_t      at;
    addr_t      seg_start;
    addr_t      seg_len;
  } fit_res_t;

  function automatic logic [5:0] log2_floor(input addr_t v);
    logic [5:0] r;
    r = '0;
    for (int i = 1; i < ADDR_BITS; i++) begin
      if (v[i]) r = 6'(i);
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/sfha_fit_eval.sv
`timescale 1ns / 1ps
module sfha_fit_eval #(
  parameter int IW = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_v,
  input  logic [IW-1:0]      in_idx,
  input  logic               seg_vld,
  input  sfha_pkg::addr_t    seg_start,
  input  sfha_pkg::addr_t    seg_len,
  input  sfha_pkg::addr_t    req,
  input  sfha_pkg::addr_t    amask,
  input  logic               low,
  output logic               out_v,
  output logic [IW-1:0]      out_idx,
  output sfha_pkg::fit_res_t res
);
  import sfha_pkg::*;

  logic          s1_v_r, out_v_r;
  logic [IW-1:0] s1_idx_r, out_idx_r;
  logic          s1_sv_r, s1_ge_r;
  addr_t         s1_pad_r, s1_d_r, s1_a_r, s1_len_r;
  logic [5:0]    s1_bk_r;
  fit_res_t      res_r, res_nxt;

  logic  fit_lo, fit_hi;
  addr_t at_lo, at_hi, sum_hi;

  // second stage: finish the fit test and form the candidate address
  always_comb begin
    fit_lo = s1_sv_r && (s1_pad_r <= s1_len_r) && (req <= s1_len_r - s1_pad_r);
    at_lo  = s1_a_r + s1_pad_r;
    sum_hi = s1_a_r + s1_d_r;
    at_hi  = sum_hi & ~amask;
    fit_hi = s1_sv_r && s1_ge_r && (at_hi >= s1_a_r);
    res_nxt.fit       = low ? fit_lo : fit_hi;
    res_nxt.bucket    = s1_bk_r;
    res_nxt.at        = low ? at_lo : at_hi;
    res_nxt.seg_start = s1_a_r;
    res_nxt.seg_len   = s1_len_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= in_v;
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r  <= in_idx;
    s1_sv_r   <= seg_vld;
    s1_ge_r   <= req <= seg_len;
    s1_pad_r  <= (addr_t'(0) - seg_start) & amask;
    s1_d_r    <= seg_len - req;
    s1_a_r    <= seg_start;
    s1_len_r  <= seg_len;
    s1_bk_r   <= log2_floor(seg_len);
    out_idx_r <= s1_idx_r;
    res_r     <= res_nxt;
  end

  assign out_v   = out_v_r;
  assign out_idx = out_idx_r;
  assign res     = res_r;

endmodule

// File: hw/rtl/segregated_fit_heap_allocator.sv
`timescale 1ns / 1ps
// Throughput: one word at a time; each word walks the free table and/or the
// record table through their single read port, one entry per cycle.
// Reset clears all control state, registers and valid bits; a write of
// heap_base or heap_size drops both tables and rebuilds them once idle.
module segregated_fit_heap_allocator #(
  parameter int FREE_SLOTS   = 64,
  parameter int RECORD_SLOTS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sfha_pkg::opcode_t   in_opcode,
  input  sfha_pkg::addr_t     in_req_size,
  input  logic [5:0]          in_align_shift,
  input  sfha_pkg::addr_t     in_target_address,
  output logic                out_valid,
  input  logic                out_stall,
  output sfha_pkg::status_t   out_status,
  output sfha_pkg::addr_t     out_result_address,
  output sfha_pkg::addr_t     out_block_size,
  output sfha_pkg::addr_t     out_used_bytes,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  sfha_pkg::cfg_idx_t  cfg_index,
  input  sfha_pkg::addr_t     cfg_data
);
  import sfha_pkg::*;

  localparam int FIW = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
  localparam int RIW = (RECORD_SLOTS > 1) ? $clog2(RECORD_SLOTS) : 1;
  localparam int SCW = (FIW > RIW) ? FIW : RIW;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_ASCAN  = 5'd1;
  localparam logic [4:0] S_ADRAIN = 5'd2;
  localparam logic [4:0] S_ALO    = 5'd3;
  localparam logic [4:0] S_AHI    = 5'd4;
  localparam logic [4:0] S_ACHK   = 5'd5;
  localparam logic [4:0] S_AWLO   = 5'd6;
  localparam logic [4:0] S_AWHI   = 5'd7;
  localparam logic [4:0] S_AREC   = 5'd8;
  localparam logic [4:0] S_RSCAN  = 5'd9;
  localparam logic [4:0] S_RDRAIN = 5'd10;
  localparam logic [4:0] S_RCHK   = 5'd11;
  localparam logic [4:0] S_FSCAN  = 5'd12;
  localparam logic [4:0] S_FDRAIN = 5'd13;
  localparam logic [4:0] S_FCHK   = 5'd14;
  localparam logic [4:0] S_FSUM   = 5'd15;
  localparam logic [4:0] S_FWR    = 5'd16;
  localparam logic [4:0] S_DONE   = 5'd17;

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  logic [4:0]              state_r, state_nxt;
  logic [SCW-1:0]          ic_r, ic_nxt;          // scan issue counter
  logic [1:0]              dc_r, dc_nxt;          // drain counter
  logic                    pend_r, pend_nxt;      // rebuild owed after base/size write
  logic                    ready_r, ready_nxt;    // heap exists
  addr_t                   base_r, base_nxt, size_r, size_nxt, thr_r, thr_nxt;
  addr_t                   used_r, used_nxt;
  logic [FREE_SLOTS-1:0]   free_v_r, free_v_nxt;
  logic [RECORD_SLOTS-1:0] rec_v_r, rec_v_nxt;
  logic                    out_v_r, out_v_nxt;
  logic                    frd_v_r, frd_v_nxt, rrd_v_r, rrd_v_nxt;
  logic                    bf_r, bf_nxt, rf_r, rf_nxt, rt_r, rt_nxt, lf_r, lf_nxt;

  // ---------------------------------------------------------------------------
  // Payload held for the word in flight
  // ---------------------------------------------------------------------------
  opcode_t        op_r, op_nxt;
  addr_t          req_r, req_nxt, amask_r, amask_nxt, ta_r, ta_nxt;
  logic           low_r, low_nxt;
  logic [FIW-1:0] frd_idx_r, frd_idx_nxt;
  logic [RIW-1:0] rrd_idx_r, rrd_idx_nxt;
  logic [5:0]     bb_r, bb_nxt;
  addr_t          bat_r, bat_nxt, bstart_r, bstart_nxt, blen_r, blen_nxt;
  logic [FIW-1:0] bslot_r, bslot_nxt;
  addr_t          lo_r, lo_nxt, hi_r, hi_nxt, tmp_r, tmp_nxt;
  logic [RIW-1:0] ridx_r, ridx_nxt;
  addr_t          rlen_r, rlen_nxt;
  logic [ADDR_BITS:0] aps_r, aps_nxt;             // released range end, may reach 2^48
  logic [FIW-1:0] rti_r, rti_nxt, lfi_r, lfi_nxt;
  addr_t          rtl_r, rtl_nxt, lfs_r, lfs_nxt, lfl_r, lfl_nxt;
  addr_t          msz_r, msz_nxt, mst_r, mst_nxt;
  status_t        st_r, st_nxt, ost_r, ost_nxt;
  addr_t          res_r, res_nxt, bsz_r, bsz_nxt;
  addr_t          oaddr_r, oaddr_nxt, obsz_r, obsz_nxt, oused_r, oused_nxt;

  // ---------------------------------------------------------------------------
  // Free segment table and allocation record table: one write, one read port
  // ---------------------------------------------------------------------------
  addr_t          fs_mem [FREE_SLOTS];
  addr_t          fl_mem [FREE_SLOTS];
  addr_t          rs_mem [RECORD_SLOTS];
  addr_t          rl_mem [RECORD_SLOTS];
  addr_t          fs_q_r, fl_q_r, rs_q_r, rl_q_r;

  logic           fw_en, rw_en;
  logic [FIW-1:0] fw_addr, fr_addr;
  logic [RIW-1:0] rw_addr, rr_addr;
  addr_t          fw_s, fw_l, rw_s, rw_l;

  always_ff @(posedge clk) begin
    if (fw_en) begin
      fs_mem[fw_addr] <= fw_s;
      fl_mem[fw_addr] <= fw_l;
    end
    fs_q_r <= fs_mem[fr_addr];
    fl_q_r <= fl_mem[fr_addr];
  end

  always_ff @(posedge clk) begin
    if (rw_en) begin
      rs_mem[rw_addr] <= rw_s;
      rl_mem[rw_addr] <= rw_l;
    end
    rs_q_r <= rs_mem[rr_addr];
    rl_q_r <= rl_mem[rr_addr];
  end

  // first empty slot of each table
  logic           free_any, rec_any;
  logic [FIW-1:0] free_idx;
  logic [RIW-1:0] rec_idx;

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = FREE_SLOTS - 1; i >= 0; i--) begin
      if (!free_v_r[i]) begin
        free_any = 1'b1;
        free_idx = FIW'(i);
      end
    end
  end

  always_comb begin
    rec_any = 1'b0;
    rec_idx = '0;
    for (int i = RECORD_SLOTS - 1; i >= 0; i--) begin
      if (!rec_v_r[i]) begin
        rec_any = 1'b1;
        rec_idx = RIW'(i);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Fit evaluator: one free entry per cycle during an allocate scan
  // ---------------------------------------------------------------------------
  logic           ev_v;
  logic [FIW-1:0] ev_idx;
  fit_res_t       ev_res;
  logic           better;

  sfha_fit_eval #(.IW(FIW)) u_fit (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_v      (frd_v_r && (op_r == OP_ALLOC)),
    .in_idx    (frd_idx_r),
    .seg_vld   (free_v_r[frd_idx_r]),
    .seg_start (fs_q_r),
    .seg_len   (fl_q_r),
    .req       (req_r),
    .amask     (amask_r),
    .low       (low_r),
    .out_v     (ev_v),
    .out_idx   (ev_idx),
    .res       (ev_res)
  );

  // smallest bucket wins; within it the lowest (low side) or highest address,
  // earliest slot on a tie
  assign better = ev_v && ev_res.fit &&
                  (!bf_r || (ev_res.bucket < bb_r) ||
                   ((ev_res.bucket == bb_r) &&
                    (low_r ? (ev_res.at < bat_r) : (ev_res.at > bat_r))));

  // rebuild: clip the heap so that it ends at or below the top of the address space
  logic [ADDR_BITS:0] room;
  addr_t              sat_len;
  assign room    = {1'b1, {ADDR_BITS{1'b0}}} - {1'b0, base_r};
  assign sat_len = ({1'b0, size_r} < room) ? size_r : room[ADDR_BITS-1:0];

  logic [ADDR_BITS:0] seg_end;
  assign seg_end = {1'b0, fs_q_r} + {1'b0, fl_q_r};

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt   = state_r;
    ic_nxt      = ic_r;
    dc_nxt      = dc_r;
    pend_nxt    = pend_r;
    ready_nxt   = ready_r;
    base_nxt    = base_r;
    size_nxt    = size_r;
    thr_nxt     = thr_r;
    used_nxt    = used_r;
    free_v_nxt  = free_v_r;
    rec_v_nxt   = rec_v_r;
    out_v_nxt   = out_v_r;
    bf_nxt      = bf_r;
    rf_nxt      = rf_r;
    rt_nxt      = rt_r;
    lf_nxt      = lf_r;
    op_nxt      = op_r;
    req_nxt     = req_r;
    amask_nxt   = amask_r;
    ta_nxt      = ta_r;
    low_nxt     = low_r;
    bb_nxt      = bb_r;
    bat_nxt     = bat_r;
    bstart_nxt  = bstart_r;
    blen_nxt    = blen_r;
    bslot_nxt   = bslot_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    tmp_nxt     = tmp_r;
    ridx_nxt    = ridx_r;
    rlen_nxt    = rlen_r;
    aps_nxt     = aps_r;
    rti_nxt     = rti_r;
    rtl_nxt     = rtl_r;
    lfi_nxt     = lfi_r;
    lfs_nxt     = lfs_r;
    lfl_nxt     = lfl_r;
    msz_nxt     = msz_r;
    mst_nxt     = mst_r;
    st_nxt      = st_r;
    res_nxt     = res_r;
    bsz_nxt     = bsz_r;
    ost_nxt     = ost_r;
    oaddr_nxt   = oaddr_r;
    obsz_nxt    = obsz_r;
    oused_nxt   = oused_r;
    frd_v_nxt   = 1'b0;
    rrd_v_nxt   = 1'b0;
    frd_idx_nxt = ic_r[FIW-1:0];
    rrd_idx_nxt = ic_r[RIW-1:0];
    fr_addr     = ic_r[FIW-1:0];
    rr_addr     = ic_r[RIW-1:0];
    fw_en       = 1'b0;
    fw_addr     = free_idx;
    fw_s        = '0;
    fw_l        = '0;
    rw_en       = 1'b0;
    rw_addr     = rec_idx;
    rw_s        = bat_r;
    rw_l        = req_r;

    // drop the result word once taken
    if (out_v_r && !out_stall) out_v_nxt = 1'b0;

    // keep the best candidate as the evaluator streams out
    if (better) begin
      bf_nxt     = 1'b1;
      bb_nxt     = ev_res.bucket;
      bat_nxt    = ev_res.at;
      bstart_nxt = ev_res.seg_start;
      blen_nxt   = ev_res.seg_len;
      bslot_nxt  = ev_idx;
    end

    // record lookup: first valid record that starts at the target
    if (rrd_v_r && rec_v_r[rrd_idx_r] && (rs_q_r == ta_r) && !rf_r) begin
      rf_nxt   = 1'b1;
      ridx_nxt = rrd_idx_r;
      rlen_nxt = rl_q_r;
    end

    // neighbour search for a release: last match on each side
    if (frd_v_r && free_v_r[frd_idx_r] && (op_r == OP_RELEASE)) begin
      if ({1'b0, fs_q_r} == aps_r) begin
        rt_nxt  = 1'b1;
        rti_nxt = frd_idx_r;
        rtl_nxt = fl_q_r;
      end
      if (seg_end == {1'b0, ta_r}) begin
        lf_nxt  = 1'b1;
        lfi_nxt = frd_idx_r;
        lfs_nxt = fs_q_r;
        lfl_nxt = fl_q_r;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (pend_r) begin
          ready_nxt = (base_r != '0) && (size_r != '0);
          pend_nxt  = 1'b0;
          if ((base_r != '0) && (size_r != '0)) begin
            fw_en         = 1'b1;
            fw_addr       = '0;
            fw_s          = base_r;
            fw_l          = sat_len;
            free_v_nxt[0] = 1'b1;
          end
        end else if (in_valid) begin
          op_nxt    = in_opcode;
          req_nxt   = in_req_size;
          amask_nxt = ~({ADDR_BITS{1'b1}} << in_align_shift);
          ta_nxt    = in_target_address;
          low_nxt   = in_req_size < thr_r;
          st_nxt    = ST_OK;
          res_nxt   = '0;
          bsz_nxt   = '0;
          ic_nxt    = '0;
          dc_nxt    = '0;
          bf_nxt    = 1'b0;
          rf_nxt    = 1'b0;
          rt_nxt    = 1'b0;
          lf_nxt    = 1'b0;
          case (in_opcode) inside
            OP_ALLOC: begin
              bsz_nxt = in_req_size;
              if (!ready_r || (in_req_size == '0)) begin
                st_nxt    = ST_REJ;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_ASCAN;
              end
            end
            OP_RELEASE, OP_QUERY: state_nxt = S_RSCAN;
            default: begin
              st_nxt    = ST_REJ;
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_ASCAN: begin
        frd_v_nxt = 1'b1;
        ic_nxt    = ic_r + 1'b1;
        if (ic_r == SCW'(FREE_SLOTS - 1)) state_nxt = S_ADRAIN;
      end

      S_ADRAIN: begin
        dc_nxt = dc_r + 1'b1;
        if (dc_r == DRAIN_LAST) begin
          if (!bf_r) begin
            st_nxt    = ST_NOFIT;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_ALO;
          end
        end
      end

      S_ALO: begin
        lo_nxt    = bat_r - bstart_r;
        tmp_nxt   = blen_r - req_r;
        state_nxt = S_AHI;
      end

      S_AHI: begin
        hi_nxt    = low_r ? (tmp_r - lo_r) : '0;
        state_nxt = S_ACHK;
      end

      S_ACHK: begin
        if (!rec_any || ((lo_r != '0) && (hi_r != '0) && !free_any)) begin
          st_nxt    = ST_FULL;
          state_nxt = S_DONE;
        end else begin
          free_v_nxt[bslot_r] = 1'b0;
          state_nxt           = S_AWLO;
        end
      end

      S_AWLO: begin
        if ((lo_r != '0) && free_any) begin
          fw_en                = 1'b1;
          fw_s                 = bstart_r;
          fw_l                 = lo_r;
          free_v_nxt[free_idx] = 1'b1;
        end
        state_nxt = S_AWHI;
      end

      S_AWHI: begin
        if ((hi_r != '0) && free_any) begin
          fw_en                = 1'b1;
          fw_s                 = bat_r + req_r;
          fw_l                 = hi_r;
          free_v_nxt[free_idx] = 1'b1;
        end
        state_nxt = S_AREC;
      end

      S_AREC: begin
        rw_en              = 1'b1;
        rec_v_nxt[rec_idx] = 1'b1;
        used_nxt           = used_r + req_r;
        res_nxt            = bat_r;
        st_nxt             = ST_OK;
        state_nxt          = S_DONE;
      end

      S_RSCAN: begin
        rrd_v_nxt = 1'b1;
        ic_nxt    = ic_r + 1'b1;
        if (ic_r == SCW'(RECORD_SLOTS - 1)) state_nxt = S_RDRAIN;
      end

      S_RDRAIN: begin
        dc_nxt = dc_r + 1'b1;
        if (dc_r == DRAIN_LAST) state_nxt = S_RCHK;
      end

      S_RCHK: begin
        dc_nxt = '0;
        ic_nxt = '0;
        if (!rf_r) begin
          st_nxt    = ST_UNKNOWN;
          state_nxt = S_DONE;
        end else if (op_r == OP_QUERY) begin
          bsz_nxt   = rlen_r;
          state_nxt = S_DONE;
        end else begin
          aps_nxt   = {1'b0, ta_r} + {1'b0, rlen_r};
          state_nxt = S_FSCAN;
        end
      end

      S_FSCAN: begin
        frd_v_nxt = 1'b1;
        ic_nxt    = ic_r + 1'b1;
        if (ic_r == SCW'(FREE_SLOTS - 1)) state_nxt = S_FDRAIN;
      end

      S_FDRAIN: begin
        dc_nxt = dc_r + 1'b1;
        if (dc_r == DRAIN_LAST) state_nxt = S_FCHK;
      end

      S_FCHK: begin
        if (!rt_r && !lf_r && !free_any) begin
          st_nxt    = ST_FULL;
          state_nxt = S_DONE;
        end else begin
          rec_v_nxt[ridx_r] = 1'b0;
          used_nxt          = used_r - rlen_r;
          bsz_nxt           = rlen_r;
          if (rt_r) free_v_nxt[rti_r] = 1'b0;
          if (lf_r) free_v_nxt[lfi_r] = 1'b0;
          msz_nxt   = rlen_r + (rt_r ? rtl_r : '0);
          mst_nxt   = lf_r ? lfs_r : ta_r;
          state_nxt = S_FSUM;
        end
      end

      S_FSUM: begin
        msz_nxt   = msz_r + (lf_r ? lfl_r : '0);
        state_nxt = S_FWR;
      end

      S_FWR: begin
        if (free_any) begin
          fw_en                = 1'b1;
          fw_s                 = mst_r;
          fw_l                 = msz_r;
          free_v_nxt[free_idx] = 1'b1;
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        // hold until the output register is free
        if (!out_v_r || !out_stall) begin
          out_v_nxt = 1'b1;
          ost_nxt   = st_r;
          oaddr_nxt = res_r;
          obsz_nxt  = bsz_r;
          oused_nxt = used_r;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // register writes; a base or size write drops both tables
    if (cfg_valid) begin
      unique case (cfg_index) inside
        CFG_BASE, CFG_SIZE: begin
          if (cfg_index == CFG_BASE) base_nxt = cfg_data;
          else                       size_nxt = cfg_data;
          pend_nxt   = 1'b1;
          free_v_nxt = '0;
          rec_v_nxt  = '0;
          used_nxt   = '0;
        end
        CFG_THRESH: thr_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ic_r     <= '0;
      dc_r     <= '0;
      pend_r   <= 1'b0;
      ready_r  <= 1'b0;
      base_r   <= '0;
      size_r   <= '0;
      thr_r    <= '0;
      used_r   <= '0;
      free_v_r <= '0;
      rec_v_r  <= '0;
      out_v_r  <= 1'b0;
      frd_v_r  <= 1'b0;
      rrd_v_r  <= 1'b0;
      bf_r     <= 1'b0;
      rf_r     <= 1'b0;
      rt_r     <= 1'b0;
      lf_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ic_r     <= ic_nxt;
      dc_r     <= dc_nxt;
      pend_r   <= pend_nxt;
      ready_r  <= ready_nxt;
      base_r   <= base_nxt;
      size_r   <= size_nxt;
      thr_r    <= thr_nxt;
      used_r   <= used_nxt;
      free_v_r <= free_v_nxt;
      rec_v_r  <= rec_v_nxt;
      out_v_r  <= out_v_nxt;
      frd_v_r  <= frd_v_nxt;
      rrd_v_r  <= rrd_v_nxt;
      bf_r     <= bf_nxt;
      rf_r     <= rf_nxt;
      rt_r     <= rt_nxt;
      lf_r     <= lf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    req_r     <= req_nxt;
    amask_r   <= amask_nxt;
    ta_r      <= ta_nxt;
    low_r     <= low_nxt;
    frd_idx_r <= frd_idx_nxt;
    rrd_idx_r <= rrd_idx_nxt;
    bb_r      <= bb_nxt;
    bat_r     <= bat_nxt;
    bstart_r  <= bstart_nxt;
    blen_r    <= blen_nxt;
    bslot_r   <= bslot_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    tmp_r     <= tmp_nxt;
    ridx_r    <= ridx_nxt;
    rlen_r    <= rlen_nxt;
    aps_r     <= aps_nxt;
    rti_r     <= rti_nxt;
    rtl_r     <= rtl_nxt;
    lfi_r     <= lfi_nxt;
    lfs_r     <= lfs_nxt;
    lfl_r     <= lfl_nxt;
    msz_r     <= msz_nxt;
    mst_r     <= mst_nxt;
    st_r      <= st_nxt;
    res_r     <= res_nxt;
    bsz_r     <= bsz_nxt;
    ost_r     <= ost_nxt;
    oaddr_r   <= oaddr_nxt;
    obsz_r    <= obsz_nxt;
    oused_r   <= oused_nxt;
  end

  // take a word only when idle and no rebuild is owed
  assign in_stall           = (state_r != S_IDLE) || pend_r;
  assign cfg_ready          = 1'b1;
  assign out_valid          = out_v_r;
  assign out_status         = ost_r;
  assign out_result_address = oaddr_r;
  assign out_block_size     = obsz_r;
  assign out_used_bytes     = oused_r;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  ap_free_wr_empty: assert property (@(posedge clk) disable iff (!rst_n)
    fw_en |-> !free_v_r[fw_addr])
    else $error("free segment written over a live entry");

  ap_rec_wr_empty: assert property (@(posedge clk) disable iff (!rst_n)
    rw_en |-> !rec_v_r[rw_addr])
    else $error("record written over a live entry");

  ap_nbr_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_FCHK) && rt_r && lf_r) |-> (rti_r != lfi_r))
    else $error("one free segment matched as both neighbours");

  ap_no_heap_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (!ready_r && !pend_r) |-> ((free_v_r == '0) && (rec_v_r == '0)))
    else $error("table entries live without a heap");

endmodule
